// File: sv/assert_macros.svh
// Assertion macros shared by the RTL of the sorted priority queue.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define SPQ_ASSERT_IMP(lbl, cond, cons, msg) \
  `SPQ_ASSERT(lbl, (cond) |-> (cons), msg)

// Checks that a condition implies a consequence in the following cycle.
`define SPQ_ASSERT_NEXT(lbl, cond, cons, msg) \
  `SPQ_ASSERT(lbl, (cond) |=> (cons), msg)

`endif

// File: sv/spq_pkg.sv
// Package of the sorted priority queue: widths, opcode and status codes,
// and the control struct passed to each storage cell. Depends on nothing.
package spq_pkg;

  localparam int unsigned SpqCapacity   = 16;
  localparam int unsigned KeyWidth      = 32;
  localparam int unsigned CountOutWidth = 5;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_PEEK    = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic shift_in;
    logic shift_out;
  } cell_ctrl_t;

endpackage

// File: sv/sorted_priority_queue_unit.sv
// Sorted priority queue: a row of key cells kept in ascending order.
// The result is registered and presented in the cycle after its item is accepted.
// Throughput: one item per cycle unless the output stalls; all cells shift at once.
// Reset clears the key count and the output valid flag; the cell keys are not reset.
// Depends on spq_pkg, spq_cell and assert_macros.svh.
`include "assert_macros.svh"

module sorted_priority_queue_unit #(
  parameter int unsigned Capacity = spq_pkg::SpqCapacity
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [1:0]                                opcode_i,
  input  logic signed [spq_pkg::KeyWidth-1:0]       key_in_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic signed [spq_pkg::KeyWidth-1:0]       key_out_o,
  output logic [1:0]                                status_o,
  output logic [spq_pkg::CountOutWidth-1:0]         entry_count_o
);
  import spq_pkg::*;

  localparam int unsigned CountWidth = $clog2(Capacity + 1);

  logic                       in_acc;
  logic [CountWidth-1:0]      count_q, count_d;
  cell_ctrl_t                 ctrl;
  logic                       is_full, is_empty;
  logic [Capacity-1:0]        occupied, stays;
  logic signed [KeyWidth-1:0] cell_key [Capacity];

  logic                       out_valid_q, out_valid_d;
  logic signed [KeyWidth-1:0] key_out_q, key_out_d;
  logic [1:0]                 status_q, status_d;
  logic [31:0]                count_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CountWidth'(Capacity));
  assign is_empty   = (count_q == '0);

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic signed [KeyWidth-1:0] left_key, right_key;
    logic                       left_stays;

    assign occupied[i] = (CountWidth'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_key   = key_in_i;
      assign left_stays = 1'b1;
    end else begin : g_body
      assign left_key   = cell_key[i-1];
      assign left_stays = stays[i-1];
    end

    if (i == Capacity - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_mid
      assign right_key = cell_key[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (occupied[i]),
      .key_in_i     (key_in_i),
      .left_key_i   (left_key),
      .left_stays_i (left_stays),
      .right_key_i  (right_key),
      .stays_o      (stays[i]),
      .key_o        (cell_key[i])
    );
  end

  always_comb begin
    ctrl.shift_in  = 1'b0;
    ctrl.shift_out = 1'b0;
    count_d        = count_q;
    if (in_acc) begin
      case (opcode_i)
        OP_INSERT: begin
          if (!is_full) begin
            ctrl.shift_in = 1'b1;
            count_d       = count_q + 1'b1;
          end
        end
        OP_EXTRACT: begin
          if (!is_empty) begin
            ctrl.shift_out = 1'b1;
            count_d        = count_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    key_out_d   = key_out_q;
    status_d    = status_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      out_valid_d = 1'b1;
      key_out_d   = '0;
      status_d    = ST_OK;
      if (opcode_i == OP_INSERT) begin
        if (is_full) begin
          status_d = ST_FULL;
        end
      end else if (opcode_i inside {OP_EXTRACT, OP_PEEK}) begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          key_out_d = cell_key[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_out_q <= key_out_d;
    status_q  <= status_d;
  end

  assign count_ext     = 32'(count_q);
  assign out_valid_o   = out_valid_q;
  assign key_out_o     = key_out_q;
  assign status_o      = status_q;
  assign entry_count_o = count_ext[CountOutWidth-1:0];

  `SPQ_ASSERT(a_count_bound, count_q <= CountWidth'(Capacity), "Key count exceeds capacity.")
  `SPQ_ASSERT_NEXT(a_insert_grows, in_acc && opcode_i == OP_INSERT && !is_full, count_q == $past(count_q) + 1'b1, "Insert did not add a key.")
  `SPQ_ASSERT_IMP(a_error_zero, out_valid_q && status_q != ST_OK, key_out_q == '0, "Error result carries a key.")
  `SPQ_ASSERT_IMP(a_head_sorted, count_q >= CountWidth'(2), cell_key[0] <= cell_key[1], "Head cells out of order.")

endmodule

// File: sv/spq_cell.sv
// One storage cell of the sorted priority queue: holds one key, compares it
// with the incoming key and takes the incoming key or a neighbour's key on insert or extract.
// Depends on spq_pkg.
module spq_cell (
  input  logic                                 clk_i,
  input  spq_pkg::cell_ctrl_t                  ctrl_i,
  input  logic                                 occupied_i,
  input  logic signed [spq_pkg::KeyWidth-1:0]  key_in_i,
  input  logic signed [spq_pkg::KeyWidth-1:0]  left_key_i,
  input  logic                                 left_stays_i,
  input  logic signed [spq_pkg::KeyWidth-1:0]  right_key_i,
  output logic                                 stays_o,
  output logic signed [spq_pkg::KeyWidth-1:0]  key_o
);
  import spq_pkg::*;

  logic signed [KeyWidth-1:0] key_q, key_d;

  assign stays_o = occupied_i && (key_q <= key_in_i);
  assign key_o   = key_q;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.shift_in) begin
      if (!stays_o) begin
        key_d = left_stays_i ? key_in_i : left_key_i;
      end
    end else if (ctrl_i.shift_out) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

// File: tb/sv/sorted_priority_queue_unit_test.sv
// Self-checking testbench for sorted_priority_queue_unit: drives insert, extract, peek and unused-opcode
// items, predicts every result from a shadow copy of the sorted store and compares them.
// Depends on spq_pkg and the RTL of the queue.
`timescale 1ns / 1ps

module sorted_priority_queue_unit_test;
  import spq_pkg::*;

  localparam int unsigned Capacity   = SpqCapacity;
  localparam logic [1:0]  OpUnused   = 2'd3;
  localparam int          CycleLimit = 200000;
  localparam int          CalmFrom   = 380;
  localparam int          CalmTo     = 560;
  localparam int          HoldAt     = 400;
  localparam int          HoldCycles = 80;

  typedef logic signed [KeyWidth-1:0] key_t;

  typedef enum logic [0:0] {
    CMD_OP,
    CMD_DRAIN
  } cmd_kind_e;

  typedef struct {
    cmd_kind_e  kind;
    logic [1:0] opcode;
    key_t       key;
  } queue_cmd_t;

  typedef struct {
    key_t                     key;
    status_e                  status;
    logic [CountOutWidth-1:0] count;
  } queue_result_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               opcode_i    = OP_INSERT;
  key_t                     key_in_i    = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  key_t                     key_out_o;
  logic [1:0]               status_o;
  logic [CountOutWidth-1:0] entry_count_o;

  queue_cmd_t    queued_cmds[$];
  queue_result_t awaited_results[$];
  key_t          shadow_keys[$];
  logic          in_handshake = 1'b0;
  int            inputs_taken = 0;
  int            errors       = 0;
  int            cycles       = 0;
  int            hold_left    = 0;
  logic          hold_done    = 1'b0;

  sorted_priority_queue_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .key_in_i     (key_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .key_out_o    (key_out_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic queue_result_t apply_to_shadow_store(logic [1:0] op, key_t key);
    queue_result_t res;
    int            slot;
    int            held;
    res.key    = '0;
    res.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (shadow_keys.size() >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < shadow_keys.size() && shadow_keys[slot] <= key) slot++;
          shadow_keys.insert(slot, key);
        end
      end
      OP_EXTRACT, OP_PEEK: begin
        if (shadow_keys.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.key = shadow_keys[0];
          if (op == OP_EXTRACT) shadow_keys.delete(0);
        end
      end
      default: ;
    endcase
    held      = shadow_keys.size();
    res.count = held[CountOutWidth-1:0];
    return res;
  endfunction

  function automatic logic calm_window();
    return inputs_taken >= CalmFrom && inputs_taken < CalmTo;
  endfunction

  function automatic key_t random_key();
    key_t k;
    case ($urandom_range(9))
      0, 1, 2: begin
        k = $urandom_range(16);
        k = k - 8;
      end
      3: begin
        case ($urandom_range(3))
          0: k = 32'h7fff_ffff;
          1: k = 32'h8000_0000;
          2: k = '0;
          default: k = 32'hffff_ffff;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] random_opcode(int insert_pct);
    int r;
    r = $urandom_range(99);
    if (r < 3) return OpUnused;
    if (r < 3 + insert_pct) return OP_INSERT;
    if ($urandom_range(2) == 0) return OP_PEEK;
    return OP_EXTRACT;
  endfunction

  function automatic void add_op(logic [1:0] op, key_t key);
    queue_cmd_t cmd;
    cmd.kind   = CMD_OP;
    cmd.opcode = op;
    cmd.key    = key;
    queued_cmds.push_back(cmd);
  endfunction

  function automatic void add_drain();
    queue_cmd_t cmd;
    cmd.kind   = CMD_DRAIN;
    cmd.opcode = OP_INSERT;
    cmd.key    = '0;
    queued_cmds.push_back(cmd);
  endfunction

  always @(negedge clk_i) begin : drive_inputs
    logic       offer;
    queue_cmd_t cmd;
    offer = in_valid_i && !in_handshake;
    if (rst_ni && !offer && queued_cmds.size() > 0) begin
      if (queued_cmds[0].kind == CMD_DRAIN) begin
        if (awaited_results.size() == 0) queued_cmds.delete(0);
      end else if (calm_window() || $urandom_range(99) >= 15) begin
        cmd = queued_cmds.pop_front();
        opcode_i <= cmd.opcode;
        key_in_i <= cmd.key;
        offer = 1'b1;
      end
    end
    in_valid_i <= offer;
  end

  always @(negedge clk_i) begin : drive_ready
    logic ready;
    ready = 1'b0;
    if (rst_ni) begin
      if (!hold_done && inputs_taken >= HoldAt) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else begin
        ready = calm_window() || $urandom_range(99) >= 15;
      end
    end
    out_ready_i <= ready;
  end

  always @(posedge clk_i) begin : watch_ports
    queue_result_t want;
    in_handshake = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, got key %0d status %0d count %0d",
                   $time, key_out_o, status_o, entry_count_o);
        end else begin
          want = awaited_results.pop_front();
          if (key_out_o !== want.key || status_o !== want.status ||
              entry_count_o !== want.count) begin
            errors++;
            $display("%0t: mismatch, expected key %0d status %0d count %0d, got key %0d status %0d count %0d",
                     $time, want.key, want.status, want.count,
                     key_out_o, status_o, entry_count_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        in_handshake = 1'b1;
        inputs_taken++;
        awaited_results.push_back(apply_to_shadow_store(opcode_i, key_in_i));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    key_t corner_keys[16];
    int   insert_mix[5];
    corner_keys = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                    32'h0000_0001, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005,
                    32'h8000_0001, 32'h7fff_fffe, 32'h0000_0064, 32'hffff_ff9c,
                    32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0003, 32'h0000_0003};
    insert_mix = '{75, 50, 25, 90, 10};

    // Empty store first, then fill it past capacity and take a few keys back out.
    add_op(OP_EXTRACT, 32'h1234_5678);
    add_op(OP_PEEK, '0);
    add_op(OpUnused, 32'hffff_ffff);
    foreach (corner_keys[i]) add_op(OP_INSERT, corner_keys[i]);
    add_op(OP_INSERT, 32'h0000_0002);
    add_op(OP_PEEK, '0);
    add_op(OP_EXTRACT, '0);
    add_op(OpUnused, '0);
    add_op(OP_EXTRACT, '0);
    add_drain();

    for (int n = 0; n < 926; n++) begin
      if (n == 600) add_drain();
      add_op(random_opcode(insert_mix[(n / 50) % 5]), random_key());
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (queued_cmds.size() != 0 || in_valid_i || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_unit.sv
tb/sv/sorted_priority_queue_unit_test.sv
